### sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int NumRounds   = 10;
  localparam int NumKeyWords = 44;

  typedef logic [3:0]   round_t;
  typedef logic [5:0]   kw_idx_t;
  typedef logic [127:0] blk_t;

  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow  = 1'b1;

  // Commands from controller to datapath and key expansion
  typedef struct packed {
    logic   load;      // capture input block, apply first round key
    logic   round;     // run one round
    logic   last;      // round without mix columns
    logic   decrypt;
    round_t rnd;       // round key to use
    logic   kx_start;  // restart key expansion
  } aes_cmd_t;

  typedef struct packed {
    logic kx_busy;
  } aes_sts_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  // byte i of the block (byte 0 = bits 127:120)
  function automatic logic [7:0] bget(input blk_t b, input int i);
    bget = b[127-8*i -: 8];
  endfunction

  function automatic blk_t enc_round(input blk_t s, input logic last);
    blk_t t, m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(r+4*c) -: 8] = sbox(bget(s, r + 4*((c+r)%4)));
    for (int c = 0; c < 4; c++) begin
      a0 = bget(t, 4*c); a1 = bget(t, 4*c+1); a2 = bget(t, 4*c+2); a3 = bget(t, 4*c+3);
      m[127-32*c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[119-32*c -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[111-32*c -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[103-32*c -: 8]  = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    enc_round = last ? t : m;
  endfunction

  function automatic logic [7:0] mul_e(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    mul_e = a8 ^ a4 ^ a2;
  endfunction
  function automatic logic [7:0] mul_b(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    mul_b = a8 ^ a2 ^ a;
  endfunction
  function automatic logic [7:0] mul_d(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    mul_d = a8 ^ a4 ^ a;
  endfunction
  function automatic logic [7:0] mul_9(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    mul_9 = a8 ^ a;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = bget(s, 4*c); a1 = bget(s, 4*c+1); a2 = bget(s, 4*c+2); a3 = bget(s, 4*c+3);
      m[127-32*c -: 8] = mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3);
      m[119-32*c -: 8] = mul_9(a0) ^ mul_e(a1) ^ mul_b(a2) ^ mul_d(a3);
      m[111-32*c -: 8] = mul_d(a0) ^ mul_9(a1) ^ mul_e(a2) ^ mul_b(a3);
      m[103-32*c -: 8] = mul_b(a0) ^ mul_d(a1) ^ mul_9(a2) ^ mul_e(a3);
    end
    inv_mix = m;
  endfunction

  // inverse shift rows and inverse sub bytes
  function automatic blk_t dec_sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(r + 4*((c+r)%4)) -: 8] = inv_sbox(bget(s, r+4*c));
    dec_sub_shift = t;
  endfunction

endpackage
`default_nettype wire

### sv/aes_key_exp.sv
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Computes one round key (four words) per cycle into a 44-word store.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_key_exp import aes_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] key,
  input  wire round_t       rd_round,
  output logic [127:0]      rd_key,
  output logic              busy
);

  logic [127:0] rk [NumRounds+1];
  logic [127:0] cur;
  logic [7:0]   rc;
  round_t       cnt;
  logic [127:0] nxt;
  logic [31:0]  tw, w0, w1, w2, w3;

  always_comb begin
    tw = {sbox(cur[23:16]), sbox(cur[15:8]), sbox(cur[7:0]), sbox(cur[31:24])}
         ^ {rc, 24'h0};
    w0 = cur[127:96] ^ tw;
    w1 = cur[95:64] ^ w0;
    w2 = cur[63:32] ^ w1;
    w3 = cur[31:0] ^ w2;
    nxt = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd1;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == round_t'(NumRounds)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur   <= key;
      rk[0] <= key;
      rc    <= 8'h01;
    end else if (busy) begin
      cur     <= nxt;
      rk[cnt] <= nxt;
      rc      <= xt(rc);
    end
  end

  assign rd_key = rk[rd_round];

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt >= 4'd1 && cnt <= round_t'(NumRounds)))
    else $error("key expansion counter out of range");
  a_busy_len: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == round_t'(NumRounds) && !start) |=> !busy)
    else $error("key expansion overran");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !rst) |=> busy && cnt == 4'd1)
    else $error("key expansion did not start");
`endif

endmodule
`default_nettype wire

### sv/aes_datapath.sv
// ----------------------------------------------------------------------------
// AES-128 datapath
// State register, which also holds the result, and one round unit shared by all rounds.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_datapath import aes_pkg::*; (
  input  wire logic         clk,
  input  wire aes_cmd_t     cmd,
  input  wire logic [127:0] blk_in,
  input  wire logic [127:0] rkey,
  output logic [127:0]      state
);

  blk_t er, dr, nxt;

  always_comb begin
    er = enc_round(state, cmd.last) ^ rkey;
    dr = dec_sub_shift(state) ^ rkey;
    if (!cmd.last) dr = inv_mix(dr);
    nxt = cmd.decrypt ? dr : er;
  end

  always_ff @(posedge clk) begin
    if (cmd.load)       state <= blk_in ^ rkey;
    else if (cmd.round) state <= nxt;
  end

endmodule
`default_nettype wire

### sv/aes_ctrl.sv
// ----------------------------------------------------------------------------
// AES-128 controller
// Sequences key expansion and the rounds, and runs both stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ctrl import aes_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire logic   in_mode,
  output logic        out_valid,
  input  wire logic   out_ready,
  input  wire logic   key_write,
  input  wire aes_sts_t sts,
  output aes_cmd_t    cmd
);

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_RUN, ST_DONE} state_t;
  state_t state;
  round_t cnt;
  logic   dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
      dec   <= 1'b0;
    end else begin
      unique case (state)
        ST_INIT: if (!sts.kx_busy && !key_write) state <= ST_IDLE;
        ST_IDLE: begin
          if (key_write) state <= ST_INIT;
          else if (in_valid && !sts.kx_busy) begin
            state <= ST_RUN;
            dec   <= in_mode;
            cnt   <= 4'd1;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 4'd1;
          if (cnt == round_t'(NumRounds)) state <= ST_DONE;
        end
        ST_DONE: if (out_ready) state <= ST_IDLE;
        default: state <= ST_INIT;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE) && !sts.kx_busy && !key_write;
  assign out_valid = (state == ST_DONE);

  always_comb begin
    cmd          = '0;
    cmd.kx_start = key_write;
    cmd.load     = in_valid && in_ready;
    cmd.round    = (state == ST_RUN);
    cmd.last     = (cnt == round_t'(NumRounds));
    cmd.decrypt  = dec;
    if (state == ST_RUN)
      cmd.rnd = dec ? round_t'(NumRounds) - cnt : cnt;
    else
      cmd.rnd = in_mode ? round_t'(NumRounds) : '0;
  end

`ifndef SYNTH
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !sts.kx_busy)
    else $error("block loaded during key expansion");
  a_run_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> (cnt >= 4'd1 && cnt <= round_t'(NumRounds)))
    else $error("round counter out of range");
  a_load_run: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_RUN)
    else $error("accepted block did not start");
`endif

endmodule
`default_nettype wire

### sv/aes128_block_cipher_core.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher core
// ECB encrypt/decrypt of one 128-bit block per beat with a stored key schedule.
// ----------------------------------------------------------------------------
// The result beat is offered after the last round. The first key addition
// happens on the input beat and the ten rounds run one per cycle through the
// single shared round unit. The result is held until taken and the core then
// returns to idle; one block is in flight at a time. After reset and after every
// key register write the key schedule is rebuilt, during which no block is
// accepted.
`default_nettype none
module aes128_block_cipher_core import aes_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,  // mode[0], block_high[64:1], block_low[128:65]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,  // out_high[63:0], out_low[127:64]
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_data
);

  logic [63:0]  key_high, key_low;
  logic         key_write;
  aes_cmd_t     cmd;
  aes_sts_t     sts;
  logic [127:0] rkey, state;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgKeyHigh: key_high <= cfg_data;
        CfgKeyLow:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // rebuild the schedule the cycle after a write lands, and once after reset
  always_ff @(posedge clk) begin
    if (rst) key_write <= 1'b1;
    else     key_write <= cfg_we;
  end

  aes_key_exp u_kx (
    .clk(clk), .rst(rst), .start(cmd.kx_start), .key({key_high, key_low}),
    .rd_round(cmd.rnd), .rd_key(rkey), .busy(sts.kx_busy)
  );

  aes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_mode(s_tdata[0]), .out_valid(m_tvalid), .out_ready(m_tready),
    .key_write(key_write || cfg_we), .sts(sts), .cmd(cmd)
  );

  aes_datapath u_dp (
    .clk(clk), .cmd(cmd), .blk_in({s_tdata[64:1], s_tdata[128:65]}),
    .rkey(rkey), .state(state)
  );

  assign m_tdata = {state[63:0], state[127:64]};

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped before taken");
  a_no_accept_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
  a_no_accept_kx: assert property (@(posedge clk) disable iff (rst)
    sts.kx_busy |-> !s_tready)
    else $error("input taken during key expansion");
`endif

endmodule
`default_nettype wire
